// ----- rtl/prg_pkg.sv -----
// Shared types and constants for the Prewitt 3x3 gradient block.
// No dependencies; imported by prg_seq, prg_pipe and prewitt_gradient_3x3.
`timescale 1ns / 1ps
`default_nettype none

package prg_pkg;

  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT        = 4096;

  localparam int PIX_W    = 8;
  localparam int GRAD_W   = 11;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 13;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST     = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST    = HEIGHT_W'(480);
  localparam logic                DIRECTION_RST = 1'b1;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_DIRECTION = 2'd2
  } reg_idx_t;

  // Position flags of one accepted beat, worked out from the raster counters
  typedef struct packed {
    logic col0;    // first column of a row
    logic top_ok;  // upper line lies inside the image
    logic mid_ok;  // middle line lies inside the image
    logic bot_ok;  // incoming line lies inside the image
    logic emit;    // beat produces a result
    logic last;    // final result of the frame
  } pos_flags_t;

endpackage

`default_nettype wire

// ----- rtl/prg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first on an address collision. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module prg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/prg_seq.sv -----
// Configuration registers (APB) and raster position counters.
// Depends on prg_pkg; feeds position flags to prg_pipe.
`timescale 1ns / 1ps
`default_nettype none

module prg_seq #(
  parameter int MAX_WIDTH = prg_pkg::DEFAULT_MAX_WIDTH,
  parameter int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [prg_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [prg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [prg_pkg::APB_DATA_W-1:0]  prdata,
  input  wire logic                            accept,
  output logic      [COL_W-1:0]                column,
  output prg_pkg::pos_flags_t                  flags,
  output logic                                 direction,
  output logic                                 restart
);
  import prg_pkg::*;

  localparam logic [HEIGHT_W-1:0] MAXW = HEIGHT_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] MAXH = HEIGHT_W'(MAX_HEIGHT);

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [COL_W-1:0]    column_next;
  logic [ROW_W-1:0]    row, row_next;
  logic [HEIGHT_W-1:0] eff_w, eff_h;
  logic [COL_W-1:0]    w_last;
  logic [ROW_W:0]      row_x, h_x, h1, h2;
  logic                wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      direction    <= DIRECTION_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_WIDTH:     image_width  <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT:    image_height <= pwdata[HEIGHT_W-1:0];
        REG_DIRECTION: direction    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:     prdata = APB_DATA_W'(image_width);
      REG_HEIGHT:    prdata = APB_DATA_W'(image_height);
      REG_DIRECTION: prdata = APB_DATA_W'(direction);
      default:       prdata = '0;
    endcase
  end

  // Geometry writes start a fresh frame
  assign restart = wr_en && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT);

  always_comb begin
    eff_w = HEIGHT_W'(image_width);
    if (eff_w < HEIGHT_W'(3)) begin
      eff_w = HEIGHT_W'(3);
    end else if (eff_w > MAXW) begin
      eff_w = MAXW;
    end
    eff_h = image_height;
    if (eff_h == '0) begin
      eff_h = HEIGHT_W'(1);
    end else if (eff_h > MAXH) begin
      eff_h = MAXH;
    end
  end

  assign w_last = COL_W'(eff_w - HEIGHT_W'(1));
  assign row_x  = (ROW_W+1)'(row);
  assign h_x    = (ROW_W+1)'(eff_h);
  assign h1     = h_x + (ROW_W+1)'(1);
  assign h2     = h_x + (ROW_W+1)'(2);

  always_comb begin
    flags.col0   = (column == '0);
    flags.top_ok = (row >= ROW_W'(2)) && (row_x < h2);
    flags.mid_ok = (row >= ROW_W'(1)) && (row_x < h1);
    flags.bot_ok = (row_x < h_x);
    flags.emit   = flags.col0 ? (row >= ROW_W'(2))
                              : ((row >= ROW_W'(1)) && (row_x <= h_x));
    flags.last   = flags.col0 && (row_x >= h1);
  end

  always_comb begin
    column_next = column;
    row_next    = row;
    if (accept) begin
      if (flags.last) begin
        column_next = '0;
        row_next    = '0;
      end else if (column == w_last) begin
        column_next = '0;
        row_next    = row + ROW_W'(1);
      end else begin
        column_next = column + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column <= '0;
      row    <= '0;
    end else begin
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/prg_pipe.sv -----
// Line store read-modify-write, 3x3 window and gradient sum, output register.
// Depends on prg_pkg and prg_ram.
`timescale 1ns / 1ps
`default_nettype none

module prg_pipe #(
  parameter int MAX_WIDTH = prg_pkg::DEFAULT_MAX_WIDTH,
  parameter int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [prg_pkg::PIX_W-1:0]          pixel,
  input  wire logic                               flush,
  input  wire logic [COL_W-1:0]                   column,
  input  wire prg_pkg::pos_flags_t                flags,
  input  wire logic                               direction,
  input  wire logic                               restart,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [prg_pkg::GRAD_W-1:0]       gradient,
  output logic                                    last
);
  import prg_pkg::*;

  localparam int SUM_W = PIX_W + 2;

  logic               accept;
  logic               s1_valid, s1_adv, s1_fwd;
  logic [COL_W-1:0]   s1_col;
  logic [PIX_W-1:0]   s1_pix;
  pos_flags_t         s1_flags;
  logic [2*PIX_W-1:0] rdata, fwd_data, entry;
  logic [PIX_W-1:0]   up, md;
  logic [PIX_W-1:0]   nc [3];
  logic [PIX_W-1:0]   cc [3];
  logic [PIX_W-1:0]   win1 [3];
  logic [PIX_W-1:0]   win2 [3];
  logic [SUM_W-1:0]   s_pos, s_neg;
  logic signed [GRAD_W-1:0] g;

  assign s1_adv   = s1_valid && (!s1_flags.emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  // Entry holds {upper line, middle line}; take the forwarded copy when the
  // previous beat wrote this entry in the same cycle as the read
  assign entry = s1_fwd ? fwd_data : rdata;
  assign up    = entry[2*PIX_W-1:PIX_W];
  assign md    = entry[PIX_W-1:0];

  prg_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata ({md, s1_pix}),
    .re    (accept),
    .raddr (column),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= column;
      s1_pix   <= flush ? '0 : pixel;
      s1_flags <= flags;
      s1_fwd   <= s1_adv && (column == s1_col);
      fwd_data <= {md, s1_pix};
    end
  end

  // New right-hand column, masked by the zero border
  assign nc[0] = s1_flags.top_ok ? up : '0;
  assign nc[1] = s1_flags.mid_ok ? md : '0;
  assign nc[2] = s1_flags.bot_ok ? s1_pix : '0;

  // At the start of a row the result belongs to the previous row's last column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cc[k] = s1_flags.col0 ? '0 : nc[k];
    end
  end

  always_comb begin
    if (direction) begin
      s_pos = SUM_W'(cc[0]) + SUM_W'(cc[1]) + SUM_W'(cc[2]);
      s_neg = SUM_W'(win1[0]) + SUM_W'(win1[1]) + SUM_W'(win1[2]);
    end else begin
      s_pos = SUM_W'(win1[2]) + SUM_W'(win2[2]) + SUM_W'(cc[2]);
      s_neg = SUM_W'(win1[0]) + SUM_W'(win2[0]) + SUM_W'(cc[0]);
    end
    g = $signed(GRAD_W'(s_pos)) - $signed(GRAD_W'(s_neg));
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int k = 0; k < 3; k++) begin
        win1[k] <= '0;
        win2[k] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        if (s1_flags.last) begin
          win1[k] <= '0;
          win2[k] <= '0;
        end else begin
          win1[k] <= s1_flags.col0 ? '0 : win2[k];
          win2[k] <= nc[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_flags.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags.emit) begin
      gradient <= g;
      last     <= s1_flags.last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/prewitt_gradient_3x3.sv -----
// Prewitt 3x3 gradient over a raster pixel stream, X or Y mask by register.
// Throughput: one beat per cycle unless the output stalls; the line RAM
// is read at accept and written back as the beat leaves stage 1, forwarded
// on a same-entry hit. Results pass stage 1, then the output register.
// Reset: registers return to 640 x 480, X mask; counters and window clear.
// The line RAM is not cleared; border masking hides entries not yet written.
`timescale 1ns / 1ps
`default_nettype none

module prewitt_gradient_3x3 #(
  parameter int MAX_WIDTH = prg_pkg::DEFAULT_MAX_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [prg_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [prg_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [prg_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [prg_pkg::PIX_W-1:0]         pixel,
  input  wire logic                              flush,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [prg_pkg::GRAD_W-1:0]      gradient,
  output logic                                   last
);
  import prg_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic             accept;
  logic [COL_W-1:0] column;
  pos_flags_t       flags;
  logic             direction;
  logic             restart;

  assign pready = 1'b1;
  assign accept = in_valid && in_ready;

  prg_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .accept    (accept),
    .column    (column),
    .flags     (flags),
    .direction (direction),
    .restart   (restart)
  );

  prg_pipe #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .flush     (flush),
    .column    (column),
    .flags     (flags),
    .direction (direction),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gradient  (gradient),
    .last      (last)
  );

endmodule

`default_nettype wire
